[design/imd_pkg.sv]
package imd_pkg;

    localparam int MapDepth    = 256;
    localparam int MaxSizeCode = 6;

    typedef enum logic [13:0] {
        PH_SIG     = 14'b00000000000001,
        PH_COMMENT = 14'b00000000000010,
        PH_MODE    = 14'b00000000000100,
        PH_CYL     = 14'b00000000001000,
        PH_HEAD    = 14'b00000000010000,
        PH_SPT     = 14'b00000000100000,
        PH_SIZE    = 14'b00000001000000,
        PH_SNUM    = 14'b00000010000000,
        PH_CMAP    = 14'b00000100000000,
        PH_HMAP    = 14'b00001000000000,
        PH_TYPE    = 14'b00010000000000,
        PH_DATA    = 14'b00100000000000,
        PH_FILL    = 14'b01000000000000,
        PH_HALT    = 14'b10000000000000
    } t_phase;

    localparam logic [2:0] EV_DATA     = 3'd0;
    localparam logic [2:0] EV_FILL     = 3'd1;
    localparam logic [2:0] EV_UNAVAIL  = 3'd2;
    localparam logic [2:0] EV_BAD_SIG  = 3'd3;
    localparam logic [2:0] EV_CYL_OVER = 3'd4;
    localparam logic [2:0] EV_HEAD_OVR = 3'd5;
    localparam logic [2:0] EV_SIZE_TBL = 3'd6;
    localparam logic [2:0] EV_BAD_MODE = 3'd7;

    localparam logic [7:0] EOF_MARK = 8'h1A;

    localparam logic REG_MAX_CYL  = 1'b0;
    localparam logic REG_MAX_HEAD = 1'b1;

    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0: v = 8'h49;
            2'd1: v = 8'h4D;
            2'd2: v = 8'h44;
            default: v = 8'h20;
        endcase
        return v;
    endfunction

endpackage

[design/imd_floppy_image_decoder_top.sv]
// Channel | Direction | Handshake                  | Payload
// image   | in        | i_image_valid / o_image_stall | i_image_byte, i_image_start
// event   | out       | o_event_valid / i_event_stall | o_event_kind ... o_sector_count
// config  | in        | APB psel/penable/pwrite     | max_cylinder, max_head
// One image byte is taken every cycle while o_image_stall is low. A byte that emits
// an event goes through a two-stage pipe: stage one parses and reads the sector-number
// and geometry maps, stage two registers the event. Maps are written in track header
// phases and map reads are used only by sector events, so no overlap needs forwarding.
// Reset is synchronous and needs no clearing pass. Stall holds the whole pipe.
module imd_floppy_image_decoder_top #(
    parameter int MAP_DEPTH     = imd_pkg::MapDepth,
    parameter int MAX_SIZE_CODE = imd_pkg::MaxSizeCode
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_image_valid,
    output logic        o_image_stall,
    input  logic [7:0]  i_image_byte,
    input  logic        i_image_start,
    output logic        o_event_valid,
    input  logic        i_event_stall,
    output logic [2:0]  o_event_kind,
    output logic [7:0]  o_cylinder,
    output logic [7:0]  o_head_number,
    output logic [7:0]  o_sector_id,
    output logic [12:0] o_byte_offset,
    output logic [7:0]  o_data_value,
    output logic        o_deleted_mark,
    output logic        o_crc_error,
    output logic        o_fm_mode,
    output logic [1:0]  o_rate_code,
    output logic [2:0]  o_size_code,
    output logic [7:0]  o_sector_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = $clog2(MAP_DEPTH);

    typedef struct packed {
        logic [2:0] kind;
        logic       sector_ev;
        logic       cmap_en;
        logic       hmap_en;
        logic [7:0] cyl;
        logic [5:0] head;
        logic [12:0] offset;
        logic [7:0] value;
        logic       deleted;
        logic       crc;
        logic       fm;
        logic [1:0] rate;
        logic [2:0] size;
        logic [7:0] count;
    } t_ev;

    logic [7:0] r_max_cyl;
    logic [5:0] r_max_head;

    imd_pkg::t_phase r_phase, n_phase;
    logic [12:0] r_cnt, n_cnt;
    logic [2:0]  r_mode, n_mode;
    logic [7:0]  r_cyl, n_cyl;
    logic [7:0]  r_hflags, n_hflags;
    logic [7:0]  r_secs, n_secs;
    logic [2:0]  r_size, n_size;
    logic [7:0]  r_sidx, n_sidx;
    logic [3:0]  r_stype, n_stype;
    logic        r_err, n_err;

    // Cylinder map in the upper byte, head map in the lower byte.
    logic [7:0]  r_snum_mem [MAP_DEPTH];
    logic [15:0] r_geo_mem [MAP_DEPTH];
    logic [7:0]  r_snum_rd;
    logic [15:0] r_geo_rd;

    logic r_s1_valid;
    t_ev  r_s1, n_s1;
    logic n_emit;

    logic r_out_valid;
    t_ev  r_out, n_out;

    logic advance, accept;
    logic cfg_wr;

    logic        wr_snum, wr_cmap, wr_hmap;
    logic [AW-1:0] wr_addr;
    logic        cnt_in_range;
    logic        sidx_in_range;
    logic [AW-1:0] rd_addr;

    // Pipe moves whenever the output register is free or being drained.
    assign advance       = !r_out_valid || !i_event_stall;
    assign o_image_stall = !advance;
    assign accept        = i_image_valid && advance;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            imd_pkg::REG_MAX_CYL:  prdata = {24'd0, r_max_cyl};
            imd_pkg::REG_MAX_HEAD: prdata = {26'd0, r_max_head};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_cyl  <= 8'd84;
            r_max_head <= 6'd1;
        end else if (cfg_wr && paddr[1:0] == 2'b00) begin
            if (paddr[2] == imd_pkg::REG_MAX_CYL) r_max_cyl <= pwdata[7:0];
            else r_max_head <= pwdata[5:0];
        end
    end

    assign cnt_in_range  = ({3'd0, r_cnt} < 16'(MAP_DEPTH));
    assign sidx_in_range = ({8'd0, r_sidx} < 16'(MAP_DEPTH));
    assign wr_addr       = r_cnt[AW-1:0];
    assign rd_addr       = AW'(r_sidx);

    always_comb begin
        logic        start;
        logic [7:0]  b;
        logic        last_sector;
        logic [13:0] dsize;
        start  = i_image_start;
        b      = i_image_byte;
        n_phase  = start ? imd_pkg::PH_SIG : r_phase;
        n_cnt    = start ? 13'd0 : r_cnt;
        n_err    = start ? 1'b0 : r_err;
        n_mode   = r_mode;
        n_cyl    = r_cyl;
        n_hflags = r_hflags;
        n_secs   = r_secs;
        n_size   = r_size;
        n_sidx   = r_sidx;
        n_stype  = r_stype;
        n_emit   = 1'b0;
        wr_snum  = 1'b0;
        wr_cmap  = 1'b0;
        wr_hmap  = 1'b0;
        last_sector = ({1'b0, r_sidx} + 9'd1) >= {1'b0, r_secs};
        dsize = 14'd128 << r_size;

        n_s1.kind      = imd_pkg::EV_DATA;
        n_s1.sector_ev = 1'b0;
        n_s1.cmap_en   = 1'b0;
        n_s1.hmap_en   = 1'b0;
        n_s1.cyl       = r_cyl;
        n_s1.head      = r_hflags[5:0];
        n_s1.offset    = 13'd0;
        n_s1.value     = b;
        n_s1.deleted   = 1'b0;
        n_s1.crc       = 1'b0;
        n_s1.fm        = 1'b0;
        n_s1.rate      = 2'd0;
        n_s1.size      = 3'd0;
        n_s1.count     = 8'd0;

        if (!n_err) begin
            unique case (n_phase)
                imd_pkg::PH_SIG: begin
                    if (b != imd_pkg::sig_byte(n_cnt[1:0])) begin
                        n_emit = 1'b1; n_s1.kind = imd_pkg::EV_BAD_SIG;
                        n_err = 1'b1; n_phase = imd_pkg::PH_HALT;
                    end else if (n_cnt >= 13'd3) begin
                        n_cnt = 13'd0; n_phase = imd_pkg::PH_COMMENT;
                    end else begin
                        n_cnt = n_cnt + 13'd1;
                    end
                end
                imd_pkg::PH_COMMENT: begin
                    if (b == imd_pkg::EOF_MARK) n_phase = imd_pkg::PH_MODE;
                end
                imd_pkg::PH_MODE: begin
                    n_mode = b[2:0];
                    if (b > 8'd5) begin
                        n_emit = 1'b1; n_s1.kind = imd_pkg::EV_BAD_MODE;
                        n_err = 1'b1; n_phase = imd_pkg::PH_HALT;
                    end else n_phase = imd_pkg::PH_CYL;
                end
                imd_pkg::PH_CYL: begin
                    n_cyl = b;
                    if (b > r_max_cyl) begin
                        n_emit = 1'b1; n_s1.kind = imd_pkg::EV_CYL_OVER;
                        n_err = 1'b1; n_phase = imd_pkg::PH_HALT;
                    end else n_phase = imd_pkg::PH_HEAD;
                end
                imd_pkg::PH_HEAD: begin
                    n_hflags = b;
                    if (b[5:0] > r_max_head) begin
                        n_emit = 1'b1; n_s1.kind = imd_pkg::EV_HEAD_OVR;
                        n_err = 1'b1; n_phase = imd_pkg::PH_HALT;
                    end else n_phase = imd_pkg::PH_SPT;
                end
                imd_pkg::PH_SPT: begin
                    n_secs = b;
                    if ({1'b0, b} > 9'(MAP_DEPTH)) begin
                        n_emit = 1'b1; n_s1.kind = imd_pkg::EV_BAD_MODE;
                        n_err = 1'b1; n_phase = imd_pkg::PH_HALT;
                    end else n_phase = imd_pkg::PH_SIZE;
                end
                imd_pkg::PH_SIZE: begin
                    n_size = (b > 8'd7) ? 3'd7 : b[2:0];
                    if (b == 8'hFF) begin
                        n_emit = 1'b1; n_s1.kind = imd_pkg::EV_SIZE_TBL;
                        n_err = 1'b1; n_phase = imd_pkg::PH_HALT;
                    end else if (b > 8'(MAX_SIZE_CODE)) begin
                        n_emit = 1'b1; n_s1.kind = imd_pkg::EV_BAD_MODE;
                        n_err = 1'b1; n_phase = imd_pkg::PH_HALT;
                    end else begin
                        n_cnt = 13'd0;
                        n_phase = (r_secs == 8'd0) ? imd_pkg::PH_MODE : imd_pkg::PH_SNUM;
                    end
                end
                imd_pkg::PH_SNUM, imd_pkg::PH_CMAP, imd_pkg::PH_HMAP: begin
                    wr_snum = cnt_in_range && (n_phase == imd_pkg::PH_SNUM);
                    wr_cmap = cnt_in_range && (n_phase == imd_pkg::PH_CMAP);
                    wr_hmap = cnt_in_range && (n_phase == imd_pkg::PH_HMAP);
                    if ((r_cnt + 13'd1) >= {5'd0, r_secs}) begin
                        n_cnt = 13'd0;
                        if (n_phase == imd_pkg::PH_SNUM && r_hflags[7])
                            n_phase = imd_pkg::PH_CMAP;
                        else if (n_phase != imd_pkg::PH_HMAP && r_hflags[6])
                            n_phase = imd_pkg::PH_HMAP;
                        else begin
                            n_sidx = 8'd0; n_phase = imd_pkg::PH_TYPE;
                        end
                    end else n_cnt = r_cnt + 13'd1;
                end
                imd_pkg::PH_TYPE: begin
                    n_stype = b[3:0];
                    if (b == 8'd0 || b > 8'd8) begin
                        n_emit = 1'b1; n_s1.kind = imd_pkg::EV_UNAVAIL;
                        n_s1.sector_ev = 1'b1; n_s1.value = 8'd0;
                        if (last_sector) n_phase = imd_pkg::PH_MODE;
                        else begin
                            n_sidx = r_sidx + 8'd1; n_phase = imd_pkg::PH_TYPE;
                        end
                    end else begin
                        n_cnt = 13'd0;
                        n_phase = b[0] ? imd_pkg::PH_DATA : imd_pkg::PH_FILL;
                    end
                end
                imd_pkg::PH_FILL: begin
                    n_emit = 1'b1; n_s1.kind = imd_pkg::EV_FILL; n_s1.sector_ev = 1'b1;
                    n_s1.deleted = (r_stype == 4'd3 || r_stype == 4'd4 ||
                                    r_stype == 4'd7 || r_stype == 4'd8);
                    n_s1.crc = (r_stype >= 4'd5 && r_stype <= 4'd8);
                    if (last_sector) n_phase = imd_pkg::PH_MODE;
                    else begin
                        n_sidx = r_sidx + 8'd1; n_phase = imd_pkg::PH_TYPE;
                    end
                end
                imd_pkg::PH_DATA: begin
                    n_emit = 1'b1; n_s1.kind = imd_pkg::EV_DATA; n_s1.sector_ev = 1'b1;
                    n_s1.offset = r_cnt;
                    n_s1.deleted = (r_stype == 4'd3 || r_stype == 4'd4 ||
                                    r_stype == 4'd7 || r_stype == 4'd8);
                    n_s1.crc = (r_stype >= 4'd5 && r_stype <= 4'd8);
                    if (({1'b0, r_cnt} + 14'd1) >= dsize) begin
                        if (last_sector) n_phase = imd_pkg::PH_MODE;
                        else begin
                            n_sidx = r_sidx + 8'd1; n_phase = imd_pkg::PH_TYPE;
                        end
                    end else n_cnt = r_cnt + 13'd1;
                end
                imd_pkg::PH_HALT: ;
                default: ;
            endcase
        end

        // Map fields only apply when the sector index addresses the maps.
        n_s1.sector_ev = n_s1.sector_ev && sidx_in_range;
        n_s1.cmap_en   = n_s1.sector_ev && r_hflags[7];
        n_s1.hmap_en   = n_s1.sector_ev && r_hflags[6];
        // Track descriptors reflect the header bytes as stored by this byte.
        n_s1.cyl   = n_cyl;
        n_s1.head  = n_hflags[5:0];
        n_s1.fm    = (n_mode < 3'd3);
        n_s1.rate  = (n_mode >= 3'd6) ? 2'(n_mode - 3'd6)
                   : (n_mode >= 3'd3) ? 2'(n_mode - 3'd3) : n_mode[1:0];
        n_s1.size  = n_size;
        n_s1.count = n_secs;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (wr_snum) r_snum_mem[wr_addr] <= i_image_byte;
            if (wr_cmap) r_geo_mem[wr_addr][15:8] <= i_image_byte;
            if (wr_hmap) r_geo_mem[wr_addr][7:0] <= i_image_byte;
        end
        if (accept) begin
            r_snum_rd <= r_snum_mem[rd_addr];
            r_geo_rd  <= r_geo_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= imd_pkg::PH_SIG;
            r_cnt    <= '0;
            r_mode   <= '0;
            r_cyl    <= '0;
            r_hflags <= '0;
            r_secs   <= '0;
            r_size   <= '0;
            r_sidx   <= '0;
            r_stype  <= '0;
            r_err    <= 1'b0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_mode   <= n_mode;
            r_cyl    <= n_cyl;
            r_hflags <= n_hflags;
            r_secs   <= n_secs;
            r_size   <= n_size;
            r_sidx   <= n_sidx;
            r_stype  <= n_stype;
            r_err    <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= accept && n_emit;
            r_out_valid <= r_s1_valid;
        end
    end

    always_comb begin
        n_out = r_s1;
        if (r_s1.cmap_en) n_out.cyl = r_geo_rd[15:8];
        if (r_s1.hmap_en) n_out.head = r_geo_rd[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (accept) r_s1 <= n_s1;
            r_out <= n_out;
        end
    end

    logic [1:0] r_out_head_hi;
    logic       r_out_sid_en;
    logic [7:0] r_out_sid;
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_head_hi <= r_s1.hmap_en ? r_geo_rd[7:6] : 2'd0;
            r_out_sid_en  <= r_s1.sector_ev;
            r_out_sid     <= r_snum_rd;
        end
    end

    assign o_event_valid  = r_out_valid;
    assign o_event_kind   = r_out.kind;
    assign o_cylinder     = r_out.cyl;
    assign o_head_number  = {r_out_head_hi, r_out.head};
    assign o_sector_id    = r_out_sid_en ? r_out_sid : 8'd0;
    assign o_byte_offset  = r_out.offset;
    assign o_data_value   = r_out.value;
    assign o_deleted_mark = r_out.deleted;
    assign o_crc_error    = r_out.crc;
    assign o_fm_mode      = r_out.fm;
    assign o_rate_code    = r_out.rate;
    assign o_size_code    = r_out.size;
    assign o_sector_count = r_out.count;

endmodule
